FILE: rtl/round_robin_schedule_stats_unit_assert.svh
// ----------------------------------------------------------------------------
// Round-robin schedule statistics: assertion macros
// Shared helpers for the concurrent checks at the end of the statistics unit.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SCHEDULE_STATS_UNIT_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULE_STATS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin schedule statistics package
// Operation codes and request type of the shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        ALU_ADD = 2'b01,
        ALU_SUB = 2'b10
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
    } t_alu_req;

endpackage

`default_nettype wire

FILE: rtl/round_robin_schedule_stats_unit.sv
// ----------------------------------------------------------------------------
// Round-robin schedule statistics unit
// Loads processes, then replays the round-robin schedule one slice at a time
// and reports total waiting time, total response time and process count; a zero quantum gives zero totals.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Direction
// input     i_valid/o_ready, arrival, burst, last     in
// result    o_valid/i_ready, totals, process_count    out
// config    i_cfg_valid/o_cfg_ready, quantum          in
//
// Loading accepts one process word per cycle; the word marked last starts the
// replay, during which the input is not ready.
// The arrival table is scanned once at start and once per arrival.
// Reset is synchronous; no clearing pass is needed.
// A waiting result is held in the output register while loading goes on.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_schedule_stats_unit #(
    parameter int unsigned MAX_PROCS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_arrival,
    input  wire logic [15:0] i_burst,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_total_waiting,
    output logic [31:0]      o_total_response,
    output logic [6:0]       o_process_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_quantum
);

    `include "round_robin_schedule_stats_unit_assert.svh"

    localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [16:0] {
        S_LOAD     = 17'h00001,
        S_INIT     = 17'h00002,
        S_SCAN_RD  = 17'h00004,
        S_SCAN_CMP = 17'h00008,
        S_ARRCHK   = 17'h00010,
        S_PREEMPT  = 17'h00020,
        S_DISP     = 17'h00040,
        S_POP_W    = 17'h00080,
        S_LD       = 17'h00100,
        S_RESP1    = 17'h00200,
        S_RESP2    = 17'h00400,
        S_RUN      = 17'h00800,
        S_ADV      = 17'h01000,
        S_FIN1     = 17'h02000,
        S_FIN2     = 17'h04000,
        S_FIN3     = 17'h08000,
        S_EMIT     = 17'h10000
    } t_state;

    function automatic logic [IW-1:0] f_wrap_inc(input logic [IW-1:0] p);
        f_wrap_inc = (p == IW'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
    endfunction

    t_state r_state, n_state;
    logic [15:0]          r_quantum, n_quantum;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_left, n_left;
    logic [CW-1:0]        r_qcnt, n_qcnt;
    logic [IW-1:0]        r_scan, n_scan;
    logic [IW-1:0]        r_nx_idx, n_nx_idx;
    logic [15:0]          r_nx_arr, n_nx_arr;
    logic                 r_nx_ok, n_nx_ok;
    logic                 r_init, n_init;
    logic                 r_pre, n_pre;
    logic [IW-1:0]        r_head, n_head;
    logic [IW-1:0]        r_tail, n_tail;
    logic [IW-1:0]        r_run, n_run;
    logic [15:0]          r_arr, n_arr;
    logic [15:0]          r_bur, n_bur;
    logic [15:0]          r_rem, n_rem;
    logic [15:0]          r_k, n_k;
    logic [31:0]          r_clk_now, n_clk_now;
    logic [31:0]          r_tmp, n_tmp;
    logic [31:0]          r_wsum, n_wsum;
    logic [31:0]          r_rsum, n_rsum;
    logic [MAX_PROCS-1:0] r_arrived, n_arrived;
    logic [MAX_PROCS-1:0] r_started, n_started;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_out_w, n_out_w;
    logic [31:0]          r_out_r, n_out_r;
    logic [6:0]           r_out_pc, n_out_pc;

    rrs_pkg::t_alu_req alu_req;
    logic [31:0]       alu_y;
    logic              alu_borrow;

    logic              tbl_we;
    logic [15:0]       bur_fix;
    logic [IW-1:0]     tbl_raddr;
    logic [31:0]       tbl_rdata;
    logic              rem_we;
    logic [15:0]       rem_new;
    logic [15:0]       rem_rdata;
    logic              q_we;
    logic [IW-1:0]     q_wdata;
    logic [IW-1:0]     q_rdata;
    logic              slice_fin;
    logic              scan_take;
    logic              scan_last;
    logic [CW+6:0]     cnt_ext;

    // Storage: process table, remaining time, ready queue
    rrs_ram #(.WIDTH(32), .DEPTH(MAX_PROCS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata ({i_arrival, bur_fix}),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    rrs_ram #(.WIDTH(16), .DEPTH(MAX_PROCS)) u_rem (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (r_run),
        .i_wdata (rem_new),
        .i_raddr (q_rdata),
        .o_rdata (rem_rdata)
    );

    rrs_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (q_wdata),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    rrs_alu u_alu (
        .i_req    (alu_req),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    // Steer the shared adder by state
    always_comb begin
        alu_req.op = rrs_pkg::ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (r_state)
            S_SCAN_CMP: begin
                alu_req.a = {16'd0, tbl_rdata[31:16]};
                alu_req.b = {16'd0, r_nx_arr};
            end
            S_ARRCHK: begin
                alu_req.a = r_clk_now;
                alu_req.b = {16'd0, r_nx_arr};
            end
            S_RESP1, S_FIN1: begin
                alu_req.a = r_clk_now;
                alu_req.b = {16'd0, r_arr};
            end
            S_RESP2: begin
                alu_req.op = rrs_pkg::ALU_ADD;
                alu_req.a  = r_rsum;
                alu_req.b  = r_tmp;
            end
            S_RUN: begin
                alu_req.a = {16'd0, r_rem};
                alu_req.b = {16'd0, r_quantum};
            end
            S_ADV: begin
                alu_req.op = rrs_pkg::ALU_ADD;
                alu_req.a  = r_clk_now;
                alu_req.b  = {16'd0, r_k};
            end
            S_FIN2: begin
                alu_req.a = r_tmp;
                alu_req.b = {16'd0, r_bur};
            end
            S_FIN3: begin
                alu_req.op = rrs_pkg::ALU_ADD;
                alu_req.a  = r_wsum;
                alu_req.b  = r_tmp;
            end
            default: begin
                alu_req.op = rrs_pkg::ALU_SUB;
            end
        endcase
    end

    // Memory port control
    assign bur_fix   = (i_burst == 16'd0) ? 16'd1 : i_burst;
    assign tbl_we    = (r_state == S_LOAD) && i_valid && (r_cnt < CW'(MAX_PROCS));
    assign tbl_raddr = (r_state == S_SCAN_RD) ? r_scan : q_rdata;
    assign slice_fin = alu_borrow || (alu_y == 32'd0);
    assign rem_new   = slice_fin ? 16'd0 : alu_y[15:0];
    assign rem_we    = (r_state == S_RUN);
    assign q_wdata   = (r_state == S_PREEMPT) ? r_run : r_nx_idx;
    assign q_we      = ((r_state == S_PREEMPT) && r_pre) ||
                       ((r_state == S_ARRCHK) && r_nx_ok && !alu_borrow);
    assign scan_take = !r_arrived[r_scan] && (!r_nx_ok || alu_borrow);
    assign scan_last = ((CW'(r_scan) + CW'(1)) == r_cnt);
    assign cnt_ext   = {7'd0, r_cnt};

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_quantum   = r_quantum;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_qcnt      = r_qcnt;
        n_scan      = r_scan;
        n_nx_idx    = r_nx_idx;
        n_nx_arr    = r_nx_arr;
        n_nx_ok     = r_nx_ok;
        n_init      = r_init;
        n_pre       = r_pre;
        n_head      = r_head;
        n_tail      = r_tail;
        n_run       = r_run;
        n_arr       = r_arr;
        n_bur       = r_bur;
        n_rem       = r_rem;
        n_k         = r_k;
        n_clk_now   = r_clk_now;
        n_tmp       = r_tmp;
        n_wsum      = r_wsum;
        n_rsum      = r_rsum;
        n_arrived   = r_arrived;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        n_out_w     = r_out_w;
        n_out_r     = r_out_r;
        n_out_pc    = r_out_pc;

        // Drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_valid) begin
            n_quantum = i_cfg_quantum;
        end

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_cnt < CW'(MAX_PROCS)) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_last) begin
                        n_wsum  = '0;
                        n_rsum  = '0;
                        n_state = (r_quantum == 16'd0) ? S_EMIT : S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_arrived = '0;
                n_started = '0;
                n_head    = '0;
                n_tail    = '0;
                n_qcnt    = '0;
                n_left    = r_cnt;
                n_nx_ok   = 1'b0;
                n_scan    = '0;
                n_init    = 1'b1;
                n_pre     = 1'b0;
                n_state   = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            // Keep the earliest unarrived process; ties go to the lower index
            S_SCAN_CMP: begin
                if (scan_take) begin
                    n_nx_ok  = 1'b1;
                    n_nx_idx = r_scan;
                    n_nx_arr = tbl_rdata[31:16];
                end
                if (scan_last) begin
                    if (r_init) begin
                        n_init    = 1'b0;
                        n_clk_now = {16'd0, scan_take ? tbl_rdata[31:16] : r_nx_arr};
                    end
                    n_state = S_ARRCHK;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            // Enqueue arrivals due by now, one per table scan
            S_ARRCHK: begin
                if (r_nx_ok && !alu_borrow) begin
                    n_tail               = f_wrap_inc(r_tail);
                    n_qcnt               = r_qcnt + 1'b1;
                    n_arrived[r_nx_idx]  = 1'b1;
                    n_nx_ok              = 1'b0;
                    n_scan               = '0;
                    n_state              = S_SCAN_RD;
                end else begin
                    n_state = S_PREEMPT;
                end
            end
            S_PREEMPT: begin
                if (r_pre) begin
                    n_tail = f_wrap_inc(r_tail);
                    n_qcnt = r_qcnt + 1'b1;
                    n_pre  = 1'b0;
                end
                n_state = S_DISP;
            end
            // Pop the queue head, or skip the idle gap to the next arrival
            S_DISP: begin
                if (r_qcnt == '0) begin
                    if (r_nx_ok) begin
                        n_clk_now = {16'd0, r_nx_arr};
                        n_state   = S_ARRCHK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_head  = f_wrap_inc(r_head);
                    n_qcnt  = r_qcnt - 1'b1;
                    n_state = S_POP_W;
                end
            end
            S_POP_W: begin
                n_run   = q_rdata;
                n_state = S_LD;
            end
            S_LD: begin
                n_arr = tbl_rdata[31:16];
                n_bur = tbl_rdata[15:0];
                if (r_started[r_run]) begin
                    n_rem   = rem_rdata;
                    n_state = S_RUN;
                end else begin
                    n_rem   = tbl_rdata[15:0];
                    n_state = S_RESP1;
                end
            end
            S_RESP1: begin
                n_tmp   = alu_y;
                n_state = S_RESP2;
            end
            S_RESP2: begin
                n_rsum             = alu_y;
                n_started[r_run]   = 1'b1;
                n_state            = S_RUN;
            end
            // Run one slice: the lesser of remaining time and quantum
            S_RUN: begin
                n_k     = slice_fin ? r_rem : r_quantum;
                n_rem   = rem_new;
                n_state = S_ADV;
            end
            S_ADV: begin
                n_clk_now = alu_y;
                if (r_rem == 16'd0) begin
                    n_state = S_FIN1;
                end else begin
                    n_pre   = 1'b1;
                    n_state = S_ARRCHK;
                end
            end
            S_FIN1: begin
                n_tmp   = alu_y;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_tmp   = alu_y;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                n_wsum  = alu_y;
                n_left  = r_left - 1'b1;
                n_state = (r_left == CW'(1)) ? S_EMIT : S_ARRCHK;
            end
            // Hand over the totals once the output register is free
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_w     = r_wsum;
                    n_out_r     = r_rsum;
                    n_out_pc    = cnt_ext[6:0];
                    n_cnt       = '0;
                    n_wsum      = '0;
                    n_rsum      = '0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_quantum   <= 16'd1;
            r_cnt       <= '0;
            r_left      <= '0;
            r_qcnt      <= '0;
            r_nx_ok     <= 1'b0;
            r_init      <= 1'b0;
            r_pre       <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_arrived   <= '0;
            r_started   <= '0;
            r_out_valid <= 1'b0;
            r_wsum      <= '0;
            r_rsum      <= '0;
        end else begin
            r_state     <= n_state;
            r_quantum   <= n_quantum;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_qcnt      <= n_qcnt;
            r_nx_ok     <= n_nx_ok;
            r_init      <= n_init;
            r_pre       <= n_pre;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_arrived   <= n_arrived;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            r_wsum      <= n_wsum;
            r_rsum      <= n_rsum;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_nx_idx  <= n_nx_idx;
        r_nx_arr  <= n_nx_arr;
        r_run     <= n_run;
        r_arr     <= n_arr;
        r_bur     <= n_bur;
        r_rem     <= n_rem;
        r_k       <= n_k;
        r_clk_now <= n_clk_now;
        r_tmp     <= n_tmp;
        r_out_w   <= n_out_w;
        r_out_r   <= n_out_r;
        r_out_pc  <= n_out_pc;
    end

    assign o_ready          = (r_state == S_LOAD);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_total_waiting  = r_out_w;
    assign o_total_response = r_out_r;
    assign o_process_count  = r_out_pc;

    `RRS_ASSERT_IMP(a_qcnt_bound, i_clk, i_rst_n, (r_state != S_LOAD), (r_qcnt <= r_cnt), "ready queue holds more entries than loaded processes")
    `RRS_ASSERT_IMP(a_idle_has_arrival, i_clk, i_rst_n, ((r_state == S_DISP) && (r_qcnt == '0)), (r_nx_ok), "empty ready queue with no pending arrival")
    `RRS_ASSERT_IMP(a_slice_nonzero, i_clk, i_rst_n, (r_state == S_ADV), (r_k != 16'd0), "time slice of zero ticks")
    `RRS_ASSERT_NXT(a_last_finish_emits, i_clk, i_rst_n, ((r_state == S_FIN3) && (r_left == CW'(1))), (r_state == S_EMIT), "last completion did not move to result")

endmodule

`default_nettype wire

FILE: rtl/rrs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/rrs_alu.sv
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// One 32-bit adder for the time sums and arrival compares of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_alu (
    input  wire rrs_pkg::t_alu_req           i_req,
    output logic [rrs_pkg::DATA_W-1:0]       o_y,
    output logic                             o_borrow
);

    logic [rrs_pkg::DATA_W:0] sum;

    // Add or subtract; top bit is the borrow on subtract
    always_comb begin
        case (i_req.op)
            rrs_pkg::ALU_ADD: sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            rrs_pkg::ALU_SUB: sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            default:          sum = '0;
        endcase
    end

    assign o_y      = sum[rrs_pkg::DATA_W-1:0];
    assign o_borrow = (i_req.op == rrs_pkg::ALU_SUB) && sum[rrs_pkg::DATA_W];

endmodule

`default_nettype wire

FILE: sim/rrs_stats_checker.sv
// ----------------------------------------------------------------------------
// Round-robin schedule statistics checker
// Watches the process, result and quantum channels, replays each loaded set
// through a round-robin scheduler of its own and compares every result word.
// ----------------------------------------------------------------------------
module rrs_stats_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_o_ready,
    input  logic [15:0] i_arrival,
    input  logic [15:0] i_burst,
    input  logic        i_last,
    input  logic        i_o_valid,
    input  logic        i_ready,
    input  logic [31:0] i_total_waiting,
    input  logic [31:0] i_total_response,
    input  logic [6:0]  i_process_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_quantum,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PROC_SLOTS = 64;

    typedef struct packed {
        logic [31:0] waiting;
        logic [31:0] response;
        logic [6:0]  count;
    } t_sched_totals;

    logic [15:0]   slice_len = 16'd1;
    logic [15:0]   set_arrival [PROC_SLOTS];
    logic [15:0]   set_burst [PROC_SLOTS];
    int            set_size = 0;
    t_sched_totals totals_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Replay the loaded set tick by tick and sum response and waiting times
    function automatic t_sched_totals schedule_totals(input int n, input logic [15:0] q);
        t_sched_totals     res;
        int                order [PROC_SLOTS];
        int                ready_fifo [PROC_SLOTS];
        int unsigned       remaining [PROC_SLOTS];
        bit                started [PROC_SLOTS];
        int                head, depth, run, next_arr, j, v, left;
        int unsigned       now, slice;
        res = '0;
        res.count = n[6:0];
        if (q == 0 || n == 0) return res;
        // stable sort of indices by arrival tick
        for (int i = 0; i < n; i++) begin
            v = i;
            j = i;
            while (j > 0 && set_arrival[order[j-1]] > set_arrival[v]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        for (int i = 0; i < n; i++) begin
            remaining[i] = 32'(set_burst[i]);
            started[i]   = 1'b0;
        end
        head = 0;
        depth = 0;
        left = n;
        next_arr = 0;
        now = 32'(set_arrival[order[0]]);
        run = order[0];
        slice = 1;
        while (left > 0) begin
            // arrivals join the tail first
            while (next_arr < n && set_arrival[order[next_arr]] == now) begin
                if (depth < PROC_SLOTS) begin
                    ready_fifo[(head + depth) % PROC_SLOTS] = order[next_arr];
                    depth++;
                end
                next_arr++;
            end
            // preempted process rejoins after them
            if (slice == q + 1 && remaining[run] > 0) begin
                if (depth < PROC_SLOTS) begin
                    ready_fifo[(head + depth) % PROC_SLOTS] = run;
                    depth++;
                end
                slice = 1;
            end
            if (slice == 1) begin
                if (depth == 0) begin
                    if (next_arr >= n) break;
                    now = 32'(set_arrival[order[next_arr]]);
                    continue;
                end
                run = ready_fifo[head];
                head = (head + 1) % PROC_SLOTS;
                depth--;
            end
            if (!started[run]) begin
                res.response += now - set_arrival[run];
                started[run] = 1'b1;
            end
            if (remaining[run] > 0) begin
                remaining[run]--;
                now++;
            end
            if (remaining[run] == 0) begin
                res.waiting += now - set_arrival[run] - set_burst[run];
                slice = 0;
                left--;
            end
            slice++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_sched_totals got, want;
        if (!i_rst_n) begin
            slice_len = 16'd1;
            set_size = 0;
            totals_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) slice_len = i_cfg_quantum;
            // load one process word; drop it once the table is full
            if (i_valid && i_o_ready) begin
                if (set_size < PROC_SLOTS) begin
                    set_arrival[set_size] = i_arrival;
                    set_burst[set_size]   = (i_burst == 0) ? 16'd1 : i_burst;
                    set_size++;
                end
                if (i_last) begin
                    totals_q.push_back(schedule_totals(set_size, slice_len));
                    set_size = 0;
                end
            end
            // compare each result word against the oldest prediction
            if (i_o_valid && i_ready) begin
                got = '{i_total_waiting, i_total_response, i_process_count};
                if (totals_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result word w=%0d r=%0d n=%0d",
                                 got.waiting, got.response, got.count);
                end else begin
                    want = totals_q.pop_front();
                    if (got != want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: expected w=%0d r=%0d n=%0d, got w=%0d r=%0d n=%0d",
                                     want.waiting, want.response, want.count,
                                     got.waiting, got.response, got.count);
                    end
                end
            end
        end
        o_pending = totals_q.size();
    end

endmodule

FILE: sim/tb_round_robin_schedule_stats_unit.sv
// ----------------------------------------------------------------------------
// Round-robin schedule statistics unit testbench
// Drives directed and random process sets under several quantum settings and
// idling patterns; the checker predicts and compares the result words.
// ----------------------------------------------------------------------------
module tb_round_robin_schedule_stats_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 5_000_000;
    localparam int  SETTLE_TICKS = 32;
    localparam int  HOLD_TICKS   = 600;
    localparam int  ITEM_TARGET  = 900;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_arrival = '0;
    logic [15:0] i_burst = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_total_waiting;
    logic [31:0] o_total_response;
    logic [6:0]  o_process_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_quantum = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    round_robin_schedule_stats_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_arrival(i_arrival), .i_burst(i_burst), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_total_waiting(o_total_waiting), .o_total_response(o_total_response),
        .o_process_count(o_process_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_quantum(i_cfg_quantum)
    );

    rrs_stats_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_o_ready(o_ready),
        .i_arrival(i_arrival), .i_burst(i_burst), .i_last(i_last),
        .i_o_valid(o_valid), .i_ready(i_ready),
        .i_total_waiting(o_total_waiting), .i_total_response(o_total_response),
        .i_process_count(o_process_count),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_quantum(i_cfg_quantum),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL round_robin_schedule_stats_unit");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_TICKS;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one process word and hold it until accepted
    task automatic send_word(input logic [15:0] arr, input logic [15:0] bur, input bit fin);
        send_idle_pct = (items_sent < 300) ? 26 : (items_sent < 600) ? 74 : 0;
        recv_idle_pct = (items_sent < 300) ? 74 : (items_sent < 600) ? 26 : 0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_arrival <= arr;
        i_burst   <= bur;
        i_last    <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drain all results, let the block settle, then write the quantum
    task automatic write_quantum(input logic [15:0] q);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_quantum <= q;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random set; wide bursts only where the quantum keeps slices few
    task automatic send_set(input int n, input bit wide);
        logic [15:0] arr, bur;
        for (int i = 0; i < n; i++) begin
            arr = $urandom_range(1) ? 16'($urandom_range(0, 31))
                                    : 16'($urandom_range(0, 65535));
            bur = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 16));
            send_word(arr, bur, i == n - 1);
        end
    endtask

    initial begin
        logic [15:0] q;
        int          set_no;
        bit          wide;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: quantum at its reset value of one
        send_word(16'd0, 16'd0, 1'b1);              // zero burst
        send_word(16'hFFFF, 16'd3, 1'b0);           // latest arrival, late start
        send_word(16'hFFFF, 16'd1, 1'b0);
        send_word(16'd0, 16'd2, 1'b1);
        send_word(16'd5, 16'd4, 1'b0);              // arrivals race preemption
        send_word(16'd7, 16'd2, 1'b0);
        send_word(16'd6, 16'd3, 1'b1);
        send_word(16'd0, 16'd1, 1'b0);              // idle gap between arrivals
        send_word(16'd40, 16'd2, 1'b1);
        // zero quantum gives zero totals
        write_quantum(16'd0);
        send_word(16'd10, 16'd5, 1'b0);
        send_word(16'd3, 16'd7, 1'b1);
        // widest quantum and widest bursts
        write_quantum(16'hFFFF);
        send_word(16'd0, 16'hFFFF, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(16'd100, 16'd1, 1'b1);
        write_quantum(16'd2);
        send_word(16'd1, 16'd5, 1'b0);
        send_word(16'd1, 16'd5, 1'b0);
        send_word(16'd2, 16'd5, 1'b1);

        // random sets across several quanta
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case ((set_no / 20) % 8)
                0: q = 16'd3;
                1: q = 16'd0;
                2: q = 16'hFFFF;
                3: q = 16'd1;
                4: q = 16'($urandom_range(1, 16));
                5: q = 16'($urandom_range(256, 65535));
                6: q = 16'd2;
                default: q = 16'($urandom_range(0, 65535));
            endcase
            if (set_no % 20 == 0) write_quantum(q);
            // long receiver hold-off while sets keep coming
            if (set_no == 25 || set_no == 95) hold_req++;
            // stop sending until every result is back
            if (set_no == 50) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            wide = (q >= 256) && $urandom_range(1);
            if (set_no % 10 == 9 && !wide)
                send_set(int'($urandom_range(60, 70)), 1'b0);   // table at or near full
            else
                send_set(int'($urandom_range(1, 8)), wide);
            set_no++;
        end

        // drain and give the verdict
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS round_robin_schedule_stats_unit");
        end else begin
            $display("FAIL round_robin_schedule_stats_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rrs_pkg.sv
rtl/rrs_ram.sv
rtl/rrs_alu.sv
rtl/round_robin_schedule_stats_unit.sv
sim/rrs_stats_checker.sv
sim/tb_round_robin_schedule_stats_unit.sv
